// ===== src/rfps_pkg.sv =====
// Shared types, register indexes, class codes and the channel shading function.
`default_nettype none
package rfps_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int RADIUS_W  = 11;
    localparam int SHADE_W   = 9;
    localparam int RSQ_W     = 2 * RADIUS_W;
    localparam int CLS_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Four corner squares and four border bands can each darken a pixel once.
    localparam int NUM_CORNERS = 4;
    localparam int NUM_BANDS   = 4;
    localparam int NUM_DARK    = NUM_CORNERS + NUM_BANDS;
    localparam int DARK_CNT_W  = $clog2(NUM_DARK + 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pixel;

    localparam t_cfg_idx CFG_FRAME_LEFT     = 3'd0;
    localparam t_cfg_idx CFG_FRAME_TOP      = 3'd1;
    localparam t_cfg_idx CFG_FRAME_WIDTH    = 3'd2;
    localparam t_cfg_idx CFG_FRAME_HEIGHT   = 3'd3;
    localparam t_cfg_idx CFG_CORNER_RADIUS  = 3'd4;
    localparam t_cfg_idx CFG_BAND_THICKNESS = 3'd5;
    localparam t_cfg_idx CFG_SHADE_FACTOR   = 3'd6;

    localparam logic [CLS_W-1:0] CLS_PASS = 2'd0;
    localparam logic [CLS_W-1:0] CLS_DARK = 2'd1;
    localparam logic [CLS_W-1:0] CLS_CUT  = 2'd2;

    // Multiply by a Q1.8 factor, drop the fraction and saturate at full scale.
    function automatic logic [CH_W-1:0] shade_ch(input logic [CH_W-1:0] ch,
                                                 input logic [SHADE_W-1:0] sf);
        logic [CH_W+SHADE_W-1:0] prod;
        prod = (CH_W+SHADE_W)'(ch) * (CH_W+SHADE_W)'(sf);
        return prod[CH_W+SHADE_W-1] ? {CH_W{1'b1}} : prod[CH_W+SHADE_W-2:CH_W];
    endfunction

endpackage
`default_nettype wire

// ===== src/rounded_frame_pixel_shader_unit.sv =====
// Pipelined rounded-corner frame shader: classifies and shades one pixel per clock.
//
// A request is one pixel (position and RGBA) and is taken at a rising edge with
// start high and busy low. busy is only high while reset is asserted, so a new
// request can be taken in every cycle. Each request yields exactly one result,
// shown for one cycle with o_valid high; the receiver cannot hold it off.
// A request passes through the input register, edge compare, squaring, distance
// compare and eight shading stages. Throughput is one pixel per clock.
// The shading chain has one 8x9 multiplier per channel in each of its eight stages,
// since a pixel in overlapping regions can be darkened up to eight times.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
// them only while no request is in flight, which the block does not enforce. Derived
// frame edges follow the registers in the next cycle.
// Reset (synchronous, active low) empties the pipeline and loads the default
// frame: 64 by 64 at the origin, radius 8, band 2, factor 0.75.
`default_nettype none
module rounded_frame_pixel_shader_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire                                            i_cfg_we,
    input  wire rfps_pkg::t_cfg_idx                        i_cfg_idx,
    input  wire [((COORD_BITS > rfps_pkg::RADIUS_W) ?
                  COORD_BITS : rfps_pkg::RADIUS_W)-1:0]    i_cfg_data,
    input  wire                                            start,
    output logic                                           busy,
    input  wire [COORD_BITS-1:0]                           i_pixel_x,
    input  wire [COORD_BITS-1:0]                           i_pixel_y,
    input  wire [rfps_pkg::CH_W-1:0]                       i_red_in,
    input  wire [rfps_pkg::CH_W-1:0]                       i_green_in,
    input  wire [rfps_pkg::CH_W-1:0]                       i_blue_in,
    input  wire [rfps_pkg::CH_W-1:0]                       i_alpha_in,
    output logic                                           o_valid,
    output logic [rfps_pkg::CH_W-1:0]                      o_red_out,
    output logic [rfps_pkg::CH_W-1:0]                      o_green_out,
    output logic [rfps_pkg::CH_W-1:0]                      o_blue_out,
    output logic [rfps_pkg::CH_W-1:0]                      o_alpha_out,
    output logic [rfps_pkg::CLS_W-1:0]                     o_region_class
);
    import rfps_pkg::*;

    // Signed working width: holds L+W and x-(L+W-r) without wrap.
    localparam int BASE_W = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
    localparam int SW     = BASE_W + 3;
    localparam int SQ_W   = 2 * SW;
    localparam int D2_W   = SQ_W + 1;
    localparam int LAT    = 12;

    typedef logic signed [SW-1:0] t_sc;

    // Configuration registers.
    logic [COORD_BITS-1:0] r_left, r_top, r_width, r_height;
    logic [RADIUS_W-1:0]   r_radius, r_thick;
    logic [SHADE_W-1:0]    r_shade;

    // Frame edges derived from the registers.
    t_sc r_e_l, r_e_t, r_e_lr, r_e_lw, r_e_rr, r_e_lb, r_e_wb;
    t_sc r_e_tr, r_e_th, r_e_bb, r_e_tb, r_e_hb;

    // Stage 1: captured request.
    logic                  r1_v;
    logic [COORD_BITS-1:0] r1_x, r1_y;
    t_pixel                r1_ch;

    // Stage 2: distances to corner centres and region flags.
    logic                 r2_v;
    t_sc                  r2_dx1, r2_dx2, r2_dy1, r2_dy2;
    logic [NUM_CORNERS-1:0] r2_corner;
    logic [NUM_BANDS-1:0]   r2_band;
    t_pixel               r2_ch;

    // Stage 3: squared distances and squared radii.
    logic                   r3_v;
    logic [SQ_W-1:0]        r3_sx1, r3_sx2, r3_sy1, r3_sy2;
    logic [RSQ_W-1:0]       r3_rsq, r3_isq;
    logic [NUM_CORNERS-1:0] r3_corner;
    logic [NUM_BANDS-1:0]   r3_band;
    t_pixel                 r3_ch;

    // Shading chain; index 0 is the classified pixel, the last is the output.
    logic                  r_pv   [0:NUM_DARK];
    t_pixel                r_pch  [0:NUM_DARK];
    logic [DARK_CNT_W-1:0] r_pn   [0:NUM_DARK];
    logic [CLS_W-1:0]      r_pcls [0:NUM_DARK];

    logic accept;

    // Stage A combinational signals.
    t_sc  a_x, a_y;
    logic a_in_l, a_in_r, a_in_t, a_in_b, a_xmid, a_ymid;

    // Stage B combinational signals.
    logic signed [SQ_W-1:0]       b_sx1, b_sx2, b_sy1, b_sy2;
    logic signed [RADIUS_W:0]     b_inner;
    logic signed [RSQ_W-1:0]      b_isq;

    // Stage C combinational signals.
    logic [D2_W-1:0]        c_d2 [0:NUM_CORNERS-1];
    logic [NUM_CORNERS-1:0] c_cut, c_dark;
    logic [DARK_CNT_W-1:0]  c_n;
    logic                   c_any_cut;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= COORD_BITS'(64);
            r_height <= COORD_BITS'(64);
            r_radius <= RADIUS_W'(8);
            r_thick  <= RADIUS_W'(2);
            r_shade  <= SHADE_W'(192);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LEFT:     r_left   <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_TOP:      r_top    <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_WIDTH:    r_width  <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_HEIGHT:   r_height <= i_cfg_data[COORD_BITS-1:0];
                CFG_CORNER_RADIUS:  r_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_BAND_THICKNESS: r_thick  <= i_cfg_data[RADIUS_W-1:0];
                CFG_SHADE_FACTOR:   r_shade  <= i_cfg_data[SHADE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_l  <= $signed(SW'(r_left));
        r_e_t  <= $signed(SW'(r_top));
        r_e_lr <= $signed(SW'(r_left) + SW'(r_radius));
        r_e_lw <= $signed(SW'(r_left) + SW'(r_width));
        r_e_rr <= $signed(SW'(r_left) + SW'(r_width) - SW'(r_radius));
        r_e_lb <= $signed(SW'(r_left) + SW'(r_thick));
        r_e_wb <= $signed(SW'(r_left) + SW'(r_width) - SW'(r_thick));
        r_e_tr <= $signed(SW'(r_top) + SW'(r_radius));
        r_e_th <= $signed(SW'(r_top) + SW'(r_height));
        r_e_bb <= $signed(SW'(r_top) + SW'(r_height) - SW'(r_radius));
        r_e_tb <= $signed(SW'(r_top) + SW'(r_thick));
        r_e_hb <= $signed(SW'(r_top) + SW'(r_height) - SW'(r_thick));
    end

    // Stage A: compare the position with the frame edges.
    always_comb begin
        a_x    = $signed(SW'(r1_x));
        a_y    = $signed(SW'(r1_y));
        a_in_l = (a_x >= r_e_l)  && (a_x < r_e_lr);
        a_in_r = (a_x >= r_e_rr) && (a_x < r_e_lw);
        a_in_t = (a_y >= r_e_t)  && (a_y < r_e_tr);
        a_in_b = (a_y >= r_e_bb) && (a_y < r_e_th);
        a_xmid = (a_x >= r_e_lr) && (a_x < r_e_rr);
        a_ymid = (a_y >= r_e_tr) && (a_y < r_e_bb);
    end

    // Stage B: squares of the distances and of both radii.
    always_comb begin
        b_sx1   = SQ_W'(r2_dx1) * SQ_W'(r2_dx1);
        b_sx2   = SQ_W'(r2_dx2) * SQ_W'(r2_dx2);
        b_sy1   = SQ_W'(r2_dy1) * SQ_W'(r2_dy1);
        b_sy2   = SQ_W'(r2_dy2) * SQ_W'(r2_dy2);
        b_inner = $signed({1'b0, r_radius}) - $signed({1'b0, r_thick});
        b_isq   = RSQ_W'(b_inner) * RSQ_W'(b_inner);
    end

    // Stage C: outer cut and inner ring per corner. Any cut clears the pixel,
    // after which further darkening leaves it at zero.
    always_comb begin
        c_d2[0] = D2_W'(r3_sx1) + D2_W'(r3_sy1);
        c_d2[1] = D2_W'(r3_sx2) + D2_W'(r3_sy1);
        c_d2[2] = D2_W'(r3_sx1) + D2_W'(r3_sy2);
        c_d2[3] = D2_W'(r3_sx2) + D2_W'(r3_sy2);
        c_n     = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            c_cut[i]  = r3_corner[i] && (c_d2[i] > D2_W'(r3_rsq));
            c_dark[i] = r3_corner[i] && !(c_d2[i] > D2_W'(r3_rsq))
                        && (c_d2[i] >= D2_W'(r3_isq));
            c_n       = c_n + DARK_CNT_W'(c_dark[i]);
        end
        for (int i = 0; i < NUM_BANDS; i++) begin
            c_n = c_n + DARK_CNT_W'(r3_band[i]);
        end
        c_any_cut = |c_cut;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int k = 0; k <= NUM_DARK; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else begin
            r1_v    <= accept;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_pv[0] <= r3_v;
            for (int k = 0; k < NUM_DARK; k++) begin
                r_pv[k+1] <= r_pv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x  <= i_pixel_x;
        r1_y  <= i_pixel_y;
        r1_ch <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};

        r2_dx1    <= a_x - r_e_lr;
        r2_dx2    <= a_x - r_e_rr;
        r2_dy1    <= a_y - r_e_tr;
        r2_dy2    <= a_y - r_e_bb;
        // Corner order: top-left, top-right, bottom-left, bottom-right.
        r2_corner <= {a_in_r & a_in_b, a_in_l & a_in_b, a_in_r & a_in_t, a_in_l & a_in_t};
        // Band order: upper, lower, left, right.
        r2_band   <= {a_ymid && (a_x >= r_e_wb) && (a_x < r_e_lw),
                      a_ymid && (a_x >= r_e_l) && (a_x < r_e_lb),
                      a_xmid && (a_y >= r_e_hb) && (a_y < r_e_th),
                      a_xmid && (a_y >= r_e_t) && (a_y < r_e_tb)};
        r2_ch     <= r1_ch;

        r3_sx1    <= $unsigned(b_sx1);
        r3_sx2    <= $unsigned(b_sx2);
        r3_sy1    <= $unsigned(b_sy1);
        r3_sy2    <= $unsigned(b_sy2);
        r3_rsq    <= RSQ_W'(r_radius) * RSQ_W'(r_radius);
        r3_isq    <= $unsigned(b_isq);
        r3_corner <= r2_corner;
        r3_band   <= r2_band;
        r3_ch     <= r2_ch;

        r_pch[0]  <= c_any_cut ? '0 : r3_ch;
        r_pn[0]   <= c_n;
        r_pcls[0] <= c_any_cut ? CLS_CUT : ((c_n != '0) ? CLS_DARK : CLS_PASS);

        // Stage k applies the k-th darkening if the pixel earned that many.
        for (int k = 0; k < NUM_DARK; k++) begin
            r_pn[k+1]   <= r_pn[k];
            r_pcls[k+1] <= r_pcls[k];
            for (int c = 0; c < NUM_CH; c++) begin
                r_pch[k+1][c] <= (r_pn[k] > DARK_CNT_W'(k)) ?
                                 shade_ch(r_pch[k][c], r_shade) : r_pch[k][c];
            end
        end
    end

    assign o_valid        = r_pv[NUM_DARK];
    assign o_red_out      = r_pch[NUM_DARK][0];
    assign o_green_out    = r_pch[NUM_DARK][1];
    assign o_blue_out     = r_pch[NUM_DARK][2];
    assign o_alpha_out    = r_pch[NUM_DARK][3];
    assign o_region_class = r_pcls[NUM_DARK];

    // Every result comes from a request taken earlier.
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

    // A cut pixel is fully cleared.
    a_cut_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region_class == CLS_CUT) |->
        (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0 && o_alpha_out == '0))
        else $error("cut pixel not transparent");

    // An unchanged pixel matches the request that produced it.
    a_pass_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region_class == CLS_PASS) |->
        (o_red_out == $past(i_red_in, LAT) && o_green_out == $past(i_green_in, LAT) &&
         o_blue_out == $past(i_blue_in, LAT) && o_alpha_out == $past(i_alpha_in, LAT)))
        else $error("unchanged pixel differs from its request");

endmodule
`default_nettype wire
